>>> design/sfca_pkg.sv
// ----------------------------------------------------------------------------
// sfca_pkg
// Shared types, codes and fixed-point constants of the structure-factor
// cosine accumulator.
// ----------------------------------------------------------------------------
package sfca_pkg;

    localparam int OP_W     = 2;
    localparam int DISP_W   = 24;
    localparam int IDX_W    = 9;
    localparam int CFG_W    = 16;
    localparam int VAL_W    = 32;
    localparam int PH_W     = 27;
    localparam int ANG_W    = 28;
    localparam int XY_W     = 32;
    localparam int TERM_W   = 17;
    localparam int PROD_W   = DISP_W + CFG_W + 1;
    localparam int CORDIC_N = 16;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ACC   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic REG_GRID_STEP  = 1'b0;
    localparam logic REG_ATOM_COUNT = 1'b1;

    localparam logic [PH_W-1:0]         TWO_PI    = 27'd105414358;
    localparam logic signed [ANG_W-1:0] PI_A      = 28'sd52707179;
    localparam logic signed [ANG_W-1:0] TWO_PI_A  = 28'sd105414358;
    localparam logic signed [ANG_W-1:0] HALF_PI_A = 28'sd26353589;
    localparam logic signed [XY_W-1:0]  GAIN_Q30  = 32'sd652032874;
    localparam logic signed [XY_W-1:0]  ROUND_Q16 = 32'sd32768;
    localparam logic signed [XY_W-1:0]  ONE_Q14   = 32'sd16384;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DISP_W-1:0] disp_x;
        logic signed [DISP_W-1:0] disp_y;
        logic signed [DISP_W-1:0] disp_z;
        logic [IDX_W-1:0]         read_index;
    } t_item;

    function automatic logic signed [ANG_W-1:0] atan_q24(input logic [3:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 28'sd13176795;
            4'd1:    v = 28'sd7778716;
            4'd2:    v = 28'sd4110060;
            4'd3:    v = 28'sd2086331;
            4'd4:    v = 28'sd1047214;
            4'd5:    v = 28'sd524117;
            4'd6:    v = 28'sd262123;
            4'd7:    v = 28'sd131069;
            4'd8:    v = 28'sd65536;
            4'd9:    v = 28'sd32768;
            4'd10:   v = 28'sd16384;
            4'd11:   v = 28'sd8192;
            4'd12:   v = 28'sd4096;
            4'd13:   v = 28'sd2048;
            4'd14:   v = 28'sd1024;
            default: v = 28'sd512;
        endcase
        return v;
    endfunction

    // modular add / subtract of reduced phases in [0, 2pi)
    function automatic logic [PH_W-1:0] phase_add(input logic [PH_W-1:0] a,
                                                  input logic [PH_W-1:0] b);
        logic [PH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, TWO_PI}) begin
            s = s - {1'b0, TWO_PI};
        end
        return s[PH_W-1:0];
    endfunction

    function automatic logic [PH_W-1:0] phase_sub(input logic [PH_W-1:0] a,
                                                  input logic [PH_W-1:0] b);
        logic [PH_W:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + {1'b0, TWO_PI} - {1'b0, b};
        end
        return s[PH_W-1:0];
    endfunction

endpackage

>>> design/sfca_front.sv
// ----------------------------------------------------------------------------
// sfca_front
// Accepts items, drops unused opcodes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module sfca_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfca_pkg::t_item  i_item,
    input  logic             i_hold,
    output logic             o_full,
    output logic             o_q_valid,
    output sfca_pkg::t_item  o_q_item,
    input  logic             i_q_pop
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    sfca_pkg::t_item r_mem [0:DEPTH-1];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    logic            keep;
    logic            enq;
    logic            deq;

    assign o_full    = (r_cnt == (PW+1)'(DEPTH)) || i_hold;
    assign keep      = (i_item.opcode == sfca_pkg::OP_CLEAR) ||
                       (i_item.opcode == sfca_pkg::OP_ACC) ||
                       (i_item.opcode == sfca_pkg::OP_READ);
    assign enq       = i_push && !o_full && keep;
    assign deq       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (deq) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({enq, deq})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> design/sfca_modred.sv
// ----------------------------------------------------------------------------
// sfca_modred
// Reduction of a signed product modulo 2pi (Q.24) to [0, 2pi): reciprocal
// quotient estimate, multiply-back, one correction step.
// ----------------------------------------------------------------------------
module sfca_modred (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [sfca_pkg::PROD_W-1:0] i_value,
    output logic                               o_busy,
    output logic [sfca_pkg::PH_W-1:0]          o_rem
);

    localparam int PW = sfca_pkg::PROD_W;
    localparam int RW = sfca_pkg::PH_W;
    localparam int QW = 13;
    localparam int HW = PW - 15;
    localparam int SH = 33;
    localparam int MW = HW + 20;
    // floor(2^46 / 2pi); magnitude is below 2^39, estimate is q or q-1
    localparam logic [19:0] RECIP = 20'd667544;

    logic [PW-1:0] r_mag;
    logic          r_neg;
    logic [QW-1:0] r_q;
    logic [RW:0]   r_diff;
    logic [RW-1:0] r_out;
    logic [2:0]    r_v;
    logic [MW-1:0] qprod;
    logic [PW-1:0] qmul;
    logic [RW:0]   red_a;
    logic [RW-1:0] red;

    always_comb begin
        qprod = r_mag[PW-3:13] * RECIP;
        qmul  = PW'(r_q) * PW'(sfca_pkg::TWO_PI);
        red_a = (r_diff >= {1'b0, sfca_pkg::TWO_PI}) ?
                r_diff - {1'b0, sfca_pkg::TWO_PI} : r_diff;
        red   = red_a[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_value[PW-1] ? PW'(-i_value) : PW'(i_value);
            r_neg <= i_value[PW-1];
        end
        if (r_v[0]) begin
            r_q <= qprod[MW-1:SH];
        end
        if (r_v[1]) begin
            r_diff <= (RW+1)'(r_mag - qmul);
        end
        if (r_v[2]) begin
            r_out <= (r_neg && red != '0) ? sfca_pkg::TWO_PI - red : red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
    end

    assign o_busy = |r_v;
    assign o_rem  = r_out;

endmodule

>>> design/sfca_div.sv
// ----------------------------------------------------------------------------
// sfca_div
// Radix-2 restoring divider, signed word by unsigned count, toward zero.
// ----------------------------------------------------------------------------
module sfca_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [sfca_pkg::VAL_W-1:0] i_num,
    input  logic [sfca_pkg::CFG_W-1:0]        i_den,
    output logic                              o_busy,
    output logic signed [sfca_pkg::VAL_W-1:0] o_quot
);

    localparam int VW = sfca_pkg::VAL_W;
    localparam int DW = sfca_pkg::CFG_W;
    localparam int CW = $clog2(VW + 1);

    logic [VW-1:0]        r_mag;
    logic [DW:0]          r_rem;
    logic [DW-1:0]        r_den;
    logic                 r_neg;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic signed [VW-1:0] r_quot;
    logic [DW:0]          t;
    logic                 qbit;

    always_comb begin
        t    = {r_rem[DW-1:0], r_mag[VW-1]};
        qbit = (t >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_num[VW-1] ? VW'(-i_num) : VW'(i_num);
            r_neg <= i_num[VW-1];
            r_den <= i_den;
            r_rem <= '0;
            if (i_den == '0) begin
                r_quot <= i_num;
            end
        end else if (r_busy && r_cnt != '0) begin
            r_mag <= {r_mag[VW-2:0], qbit};
            r_rem <= qbit ? t - {1'b0, r_den} : t;
        end else if (r_busy) begin
            r_quot <= r_neg ? -$signed(r_mag) : $signed(r_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_den != '0);
            r_cnt  <= CW'(VW);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

>>> design/sfca_cordic.sv
// ----------------------------------------------------------------------------
// sfca_cordic
// Pipelined rotation-mode CORDIC: quadrant fold, 16 stages, Q1.14 cosine
// scaled by the half-space weight into a signed Q2.14 term.
// ----------------------------------------------------------------------------
module sfca_cordic #(
    parameter int AW = 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [sfca_pkg::PH_W-1:0]          i_phase,
    input  logic [AW-1:0]                      i_addr,
    input  logic                               i_double,
    output logic                               o_valid,
    output logic signed [sfca_pkg::TERM_W-1:0] o_term,
    output logic [AW-1:0]                      o_addr,
    output logic                               o_busy
);

    localparam int N  = sfca_pkg::CORDIC_N;
    localparam int XW = sfca_pkg::XY_W;
    localparam int ZW = sfca_pkg::ANG_W;
    localparam int TERM_W_L = sfca_pkg::TERM_W;

    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [AW-1:0]        r_a [0:N];
    logic                 r_d [0:N];
    logic                 r_f [0:N];
    logic [N:0]           r_v;
    logic signed [XW-1:0] n_x [1:N];
    logic signed [XW-1:0] n_y [1:N];
    logic signed [ZW-1:0] n_z [1:N];

    logic signed [ZW-1:0]     a0;
    logic signed [ZW-1:0]     a1;
    logic                     f0;
    logic signed [XW-1:0]     c;
    logic signed [XW-1:0]     cc;
    logic signed [TERM_W_L-1:0] term;

    logic                       r_ov;
    logic signed [TERM_W_L-1:0] r_oterm;
    logic [AW-1:0]              r_oaddr;

    always_comb begin
        a0 = $signed({1'b0, i_phase});
        if (a0 >= sfca_pkg::PI_A) begin
            a0 = a0 - sfca_pkg::TWO_PI_A;
        end
        a1 = a0;
        f0 = 1'b0;
        if (a0 > sfca_pkg::HALF_PI_A) begin
            a1 = a0 - sfca_pkg::PI_A;
            f0 = 1'b1;
        end else if (a0 < -sfca_pkg::HALF_PI_A) begin
            a1 = a0 + sfca_pkg::PI_A;
            f0 = 1'b1;
        end
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (!r_z[k][ZW-1]) begin
                n_x[k+1] = r_x[k] - (r_y[k] >>> k);
                n_y[k+1] = r_y[k] + (r_x[k] >>> k);
                n_z[k+1] = r_z[k] - sfca_pkg::atan_q24(4'(k));
            end else begin
                n_x[k+1] = r_x[k] + (r_y[k] >>> k);
                n_y[k+1] = r_y[k] - (r_x[k] >>> k);
                n_z[k+1] = r_z[k] + sfca_pkg::atan_q24(4'(k));
            end
        end
    end

    always_comb begin
        c = (r_x[N] + sfca_pkg::ROUND_Q16) >>> 16;
        cc = c;
        if (c > sfca_pkg::ONE_Q14) begin
            cc = sfca_pkg::ONE_Q14;
        end else if (c < -sfca_pkg::ONE_Q14) begin
            cc = -sfca_pkg::ONE_Q14;
        end
        if (r_f[N]) begin
            cc = -cc;
        end
        if (r_d[N]) begin
            cc = cc <<< 1;
        end
        term = TERM_W_L'(cc);
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= sfca_pkg::GAIN_Q30;
        r_y[0] <= '0;
        r_z[0] <= a1;
        r_f[0] <= f0;
        r_a[0] <= i_addr;
        r_d[0] <= i_double;
        for (int k = 1; k <= N; k++) begin
            r_x[k] <= n_x[k];
            r_y[k] <= n_y[k];
            r_z[k] <= n_z[k];
            r_f[k] <= r_f[k-1];
            r_a[k] <= r_a[k-1];
            r_d[k] <= r_d[k-1];
        end
        r_oterm <= term;
        r_oaddr <= r_a[N];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_v  <= {r_v[N-1:0], i_valid};
            r_ov <= r_v[N];
        end
    end

    assign o_valid = r_ov;
    assign o_term  = r_oterm;
    assign o_addr  = r_oaddr;
    assign o_busy  = (|r_v) || r_ov;

endmodule

>>> design/sfca_back.sv
// ----------------------------------------------------------------------------
// sfca_back
// Executes queued items: clear sweep, phase walk over the half grid feeding
// the CORDIC pipeline with read-modify-write accumulation, and reads through
// the divider into the result register.
// ----------------------------------------------------------------------------
module sfca_back #(
    parameter int GRID_HALF = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [sfca_pkg::CFG_W-1:0]         i_grid_step,
    input  logic [sfca_pkg::CFG_W-1:0]         i_atom_count,
    input  logic                               i_q_valid,
    input  sfca_pkg::t_item                    i_q_item,
    output logic                               o_q_pop,
    output logic                               o_init,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic signed [sfca_pkg::VAL_W-1:0]  o_factor_value,
    output logic [sfca_pkg::IDX_W-1:0]         o_index_echo
);

    localparam int SIDE  = 2 * GRID_HALF + 1;
    localparam int PLANE = SIDE * SIDE;
    localparam int TOTAL = PLANE * SIDE;
    localparam int AW    = $clog2(TOTAL);
    localparam int SW    = $clog2(SIDE);
    localparam int START = GRID_HALF * PLANE;
    localparam int PH    = sfca_pkg::PH_W;
    localparam int VW    = sfca_pkg::VAL_W;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MODS  = 4'd4;
    localparam logic [3:0] S_MODW  = 4'd5;
    localparam logic [3:0] S_BASE  = 4'd6;
    localparam logic [3:0] S_RUN   = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;
    localparam logic [3:0] S_RD0   = 4'd9;
    localparam logic [3:0] S_RD1   = 4'd10;
    localparam logic [3:0] S_RDW   = 4'd11;

    logic [3:0]      r_state;
    logic [3:0]      n_state;
    sfca_pkg::t_item r_item;
    logic [AW-1:0]   r_cnt;

    logic signed [sfca_pkg::PROD_W-1:0] r_px;
    logic signed [sfca_pkg::PROD_W-1:0] r_py;
    logic signed [sfca_pkg::PROD_W-1:0] r_pz;
    logic [PH-1:0] rx;
    logic [PH-1:0] ry;
    logic [PH-1:0] rz;
    logic          bx;
    logic          by;
    logic          bz;
    logic          mod_start;

    logic [PH-1:0] r_cur;
    logic [PH-1:0] r_row;
    logic [PH-1:0] r_plane;
    logic [SW-1:0] r_iy;
    logic [SW-1:0] r_iz;
    logic          r_dbl;
    logic [AW-1:0] r_addr;
    logic [PH-1:0] base_next;
    logic [PH-1:0] row_next;
    logic [PH-1:0] plane_next;

    logic                              c_valid;
    logic signed [sfca_pkg::TERM_W-1:0] c_term;
    logic [AW-1:0]                     c_addr;
    logic                              c_busy;

    logic signed [VW-1:0] mem [0:TOTAL-1];
    logic signed [VW-1:0] r_rdata;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [VW-1:0] wdata;
    logic                 r_acc_v;
    logic [AW-1:0]        r_acc_addr;
    logic signed [sfca_pkg::TERM_W-1:0] r_acc_term;
    logic signed [VW:0]   sum;

    logic                 in_range;
    logic                 div_start;
    logic                 div_busy;
    logic signed [VW-1:0] div_quot;

    logic                 r_out_v;
    logic signed [VW-1:0] r_out_val;
    logic [sfca_pkg::IDX_W-1:0] r_out_idx;

    sfca_modred u_mod_x (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
                         .i_value(r_px), .o_busy(bx), .o_rem(rx));
    sfca_modred u_mod_y (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
                         .i_value(r_py), .o_busy(by), .o_rem(ry));
    sfca_modred u_mod_z (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
                         .i_value(r_pz), .o_busy(bz), .o_rem(rz));

    sfca_cordic #(.AW(AW)) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_state == S_RUN),
        .i_phase  (r_cur),
        .i_addr   (r_addr),
        .i_double (r_dbl),
        .o_valid  (c_valid),
        .o_term   (c_term),
        .o_addr   (c_addr),
        .o_busy   (c_busy)
    );

    sfca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (in_range ? r_rdata : '0),
        .i_den   (i_atom_count),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign mod_start  = (r_state == S_MODS);
    assign div_start  = (r_state == S_RD1);
    assign in_range   = ({23'd0, r_item.read_index} < 32'(TOTAL));
    assign base_next  = sfca_pkg::phase_sub(r_cur,
                            (r_cnt < AW'(GRID_HALF)) ? ry : rz);
    assign row_next   = sfca_pkg::phase_add(r_row, ry);
    assign plane_next = sfca_pkg::phase_add(r_plane, rx);

    // memory ports
    always_comb begin
        sum   = {r_rdata[VW-1], r_rdata} + (VW+1)'(r_acc_term);
        raddr = (r_state == S_RD0) ? AW'(r_item.read_index) : c_addr;
        if (r_state == S_INIT || r_state == S_CLR) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = '0;
        end else begin
            we    = r_acc_v;
            waddr = r_acc_addr;
            if (sum[VW] != sum[VW-1]) begin
                wdata = sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
            end else begin
                wdata = sum[VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        r_acc_addr <= c_addr;
        r_acc_term <= c_term;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT, S_CLR: if (r_cnt == AW'(TOTAL - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.opcode)
                        sfca_pkg::OP_CLEAR: n_state = S_CLR;
                        sfca_pkg::OP_ACC:   n_state = S_MUL;
                        default:            n_state = S_RD0;
                    endcase
                end
            end
            S_MUL:   n_state = S_MODS;
            S_MODS:  n_state = S_MODW;
            S_MODW:  if (!bx && !by && !bz) n_state = S_BASE;
            S_BASE:  if (r_cnt == AW'(2 * GRID_HALF - 1)) n_state = S_RUN;
            S_RUN:   if (r_addr == AW'(TOTAL - 1)) n_state = S_DRAIN;
            S_DRAIN: if (!c_busy && !r_acc_v) n_state = S_IDLE;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RDW;
            S_RDW:   if (!div_busy && !r_out_v) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) begin
            r_item <= i_q_item;
        end
        if (r_state == S_MUL) begin
            r_px <= r_item.disp_x * $signed({1'b0, i_grid_step});
            r_py <= r_item.disp_y * $signed({1'b0, i_grid_step});
            r_pz <= r_item.disp_z * $signed({1'b0, i_grid_step});
        end
        if (r_state == S_MODW) begin
            r_cur <= '0;
        end else if (r_state == S_BASE) begin
            r_cur   <= base_next;
            r_row   <= base_next;
            r_plane <= base_next;
            r_iy    <= '0;
            r_iz    <= '0;
            r_dbl   <= 1'b0;
            r_addr  <= AW'(START);
        end else if (r_state == S_RUN) begin
            r_addr <= r_addr + 1'b1;
            if (r_iz != SW'(SIDE - 1)) begin
                r_cur <= sfca_pkg::phase_add(r_cur, rz);
                r_iz  <= r_iz + 1'b1;
            end else if (r_iy != SW'(SIDE - 1)) begin
                r_cur <= row_next;
                r_row <= row_next;
                r_iz  <= '0;
                r_iy  <= r_iy + 1'b1;
            end else begin
                r_cur   <= plane_next;
                r_row   <= plane_next;
                r_plane <= plane_next;
                r_iz    <= '0;
                r_iy    <= '0;
                r_dbl   <= 1'b1;
            end
        end
        if (r_state == S_RDW && !div_busy && !r_out_v) begin
            r_out_val <= div_quot;
            r_out_idx <= r_item.read_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_acc_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc_v <= c_valid;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_RDW && !div_busy && !r_out_v) begin
                r_out_v <= 1'b1;
            end else if (i_pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_q_pop        = (r_state == S_IDLE);
    assign o_init         = (r_state == S_INIT);
    assign o_empty        = !r_out_v;
    assign o_factor_value = r_out_val;
    assign o_index_echo   = r_out_idx;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!c_busy && !r_acc_v))
        else $error("back idle with accumulations in flight");

    a_phase_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cur < sfca_pkg::TWO_PI))
        else $error("phase walk left [0, 2pi)");

    a_acc_half_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_v |-> (r_acc_addr >= AW'(START)))
        else $error("accumulation outside nonnegative x half");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDW && !div_busy && !r_out_v) |=> (r_out_v && r_state == S_IDLE))
        else $error("read result not registered");

endmodule

>>> design/structure_factor_cosine_accumulator.sv
// ----------------------------------------------------------------------------
// structure_factor_cosine_accumulator
// Cosine structure-factor accumulator over a cubic reciprocal grid.
//
//   channel  | handshake        | words
//   ---------+------------------+--------------------------------------------
//   input    | push / full      | opcode, disp_x/y/z, read_index
//   result   | pop / empty      | factor_value, index_echo
//   config   | i_cfg_we         | i_cfg_index (0 step, 1 count), i_cfg_data
//
// Accumulate: phase reduction, then one grid point per cycle into the CORDIC
// pipeline over the half grid, then pipeline drain. Clear: one memory word
// per cycle. Read: through the serial divider. Reset runs a clearing pass
// over all (2H+1)^3 words with full held high. A 4-word queue decouples
// intake from execution.
// ----------------------------------------------------------------------------
module structure_factor_cosine_accumulator #(
    parameter int GRID_HALF = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [sfca_pkg::OP_W-1:0]         i_opcode,
    input  logic signed [sfca_pkg::DISP_W-1:0] i_disp_x,
    input  logic signed [sfca_pkg::DISP_W-1:0] i_disp_y,
    input  logic signed [sfca_pkg::DISP_W-1:0] i_disp_z,
    input  logic [sfca_pkg::IDX_W-1:0]        i_read_index,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [sfca_pkg::VAL_W-1:0] o_factor_value,
    output logic [sfca_pkg::IDX_W-1:0]        o_index_echo,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [sfca_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [sfca_pkg::CFG_W-1:0] r_grid_step;
    logic [sfca_pkg::CFG_W-1:0] r_atom_count;
    sfca_pkg::t_item            in_item;
    sfca_pkg::t_item            q_item;
    logic                       q_valid;
    logic                       q_pop;
    logic                       init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_step  <= 16'd4096;
            r_atom_count <= 16'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sfca_pkg::REG_ATOM_COUNT) begin
                r_atom_count <= i_cfg_data;
            end else begin
                r_grid_step <= i_cfg_data;
            end
        end
    end

    assign in_item.opcode     = i_opcode;
    assign in_item.disp_x     = i_disp_x;
    assign in_item.disp_y     = i_disp_y;
    assign in_item.disp_z     = i_disp_z;
    assign in_item.read_index = i_read_index;

    sfca_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (in_item),
        .i_hold    (init_busy),
        .o_full    (full),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    sfca_back #(.GRID_HALF(GRID_HALF)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grid_step    (r_grid_step),
        .i_atom_count   (r_atom_count),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_init         (init_busy),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_factor_value (o_factor_value),
        .o_index_echo   (o_index_echo)
    );

endmodule

>>> tb/sv/structure_factor_cosine_accumulator_tb.sv
// ----------------------------------------------------------------------------
// Structure-factor cosine accumulator testbench
// Drives clear, accumulate, read and unused-opcode words through the queue
// ports under several register settings, with random idling on both sides
// and one long receiver stall. An in-bench model of the grid accumulators
// predicts every read and each popped word is checked against it in order.
// ----------------------------------------------------------------------------
module structure_factor_cosine_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HALF       = 3;
    localparam int  SIDE       = 2 * HALF + 1;
    localparam int  CELLS      = SIDE * SIDE * SIDE;
    localparam int  LIMIT      = 3000000;
    localparam int  IDLE_WAIT  = 1400;
    localparam int  OW         = sfca_pkg::OP_W;
    localparam int  DW         = sfca_pkg::DISP_W;
    localparam int  IW         = sfca_pkg::IDX_W;
    localparam int  VW         = sfca_pkg::VAL_W;
    localparam int  CW         = sfca_pkg::CFG_W;
    localparam logic [OW-1:0] OP_NONE = 2'd3;

    typedef struct {
        logic signed [VW-1:0] value;
        logic [IW-1:0]        index;
    } t_sf_word;

    class sf_scoreboard;
        int               sums[CELLS];
        longint           step;
        longint           count;
        t_sf_word         pending[$];
        int               errors;
        longint           atan_tab[16] = '{13176795, 7778716, 4110060, 2086331,
            1047214, 524117, 262123, 131069, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512};

        function void reset_state();
            foreach (sums[i]) sums[i] = 0;
            step   = 4096;
            count  = 1;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [CW-1:0] data);
            if (idx == sfca_pkg::REG_GRID_STEP) step = data;
            else count = data;
        endfunction

        function longint cosine(longint phase);
            longint a, x, y, xs, ys, c;
            bit     flip;
            a = phase % longint'(sfca_pkg::TWO_PI_A);
            flip = 0;
            x = sfca_pkg::GAIN_Q30;
            y = 0;
            if (a < 0) a += sfca_pkg::TWO_PI_A;
            if (a >= longint'(sfca_pkg::PI_A)) a -= sfca_pkg::TWO_PI_A;
            if (a > longint'(sfca_pkg::HALF_PI_A)) begin
                a -= sfca_pkg::PI_A;
                flip = 1;
            end else if (a < -longint'(sfca_pkg::HALF_PI_A)) begin
                a += sfca_pkg::PI_A;
                flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (a >= 0) begin
                    x -= ys; y += xs; a -= atan_tab[i];
                end else begin
                    x += ys; y -= xs; a += atan_tab[i];
                end
            end
            c = (x + 32768) >>> 16;
            if (c > 16384) c = 16384;
            if (c < -16384) c = -16384;
            return flip ? -c : c;
        endfunction

        function void note_word(logic [OW-1:0] op, logic signed [DW-1:0] dx,
                                logic signed [DW-1:0] dy,
                                logic signed [DW-1:0] dz,
                                logic [IW-1:0] ri);
            longint   n, s;
            int       k;
            t_sf_word w;
            case (op)
                sfca_pkg::OP_CLEAR: foreach (sums[i]) sums[i] = 0;
                sfca_pkg::OP_ACC: begin
                    for (int ix = 0; ix <= HALF; ix++)
                        for (int iy = -HALF; iy <= HALF; iy++)
                            for (int iz = -HALF; iz <= HALF; iz++) begin
                                n = ix * longint'(dx) + iy * longint'(dy)
                                    + iz * longint'(dz);
                                k = ((ix + HALF) * SIDE + iy + HALF) * SIDE + iz + HALF;
                                s = longint'(sums[k])
                                    + (ix == 0 ? 1 : 2) * cosine(n * step);
                                if (s > 64'sd2147483647) s = 64'sd2147483647;
                                if (s < -64'sd2147483648) s = -64'sd2147483648;
                                sums[k] = int'(s);
                            end
                end
                sfca_pkg::OP_READ: begin
                    s = 0;
                    if (ri < CELLS) begin
                        s = sums[ri];
                        if (count != 0) s = s / count;
                    end
                    w.value = s[31:0];
                    w.index = ri;
                    pending.push_back(w);
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic signed [VW-1:0] v, logic [IW-1:0] ri);
            t_sf_word w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word value=%0d index=%0d", $realtime, v, ri);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (v !== w.value) begin
                $display("%0t: factor_value expected %0d actual %0d", $realtime,
                         w.value, v);
                errors++;
            end
            if (ri !== w.index) begin
                $display("%0t: index_echo expected %0d actual %0d", $realtime,
                         w.index, ri);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [OW-1:0]         i_opcode;
    logic signed [DW-1:0]  i_disp_x;
    logic signed [DW-1:0]  i_disp_y;
    logic signed [DW-1:0]  i_disp_z;
    logic [IW-1:0]         i_read_index;
    logic                  empty;
    logic                  pop;
    logic signed [VW-1:0]  o_factor_value;
    logic [IW-1:0]         o_index_echo;
    logic                  i_cfg_we;
    logic                  i_cfg_index;
    logic [CW-1:0]         i_cfg_data;

    sf_scoreboard sb;
    int           cycles;
    bit           burst;
    bit           hold_req;

    structure_factor_cosine_accumulator dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            sb.note_word(i_opcode, i_disp_x, i_disp_y, i_disp_z, i_read_index);
        if (i_rst_n && pop && !empty)
            sb.check_word(o_factor_value, o_index_echo);
    end

    function automatic int draw_gap();
        return burst ? 0 : int'($urandom_range(0, 8));
    endfunction

    task automatic send_word(logic [OW-1:0] op, logic [DW-1:0] dx,
                             logic [DW-1:0] dy, logic [DW-1:0] dz,
                             logic [IW-1:0] ri);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode     <= op;
        i_disp_x     <= dx;
        i_disp_y     <= dy;
        i_disp_z     <= dz;
        i_read_index <= ri;
        push         <= 1;
        do @(posedge i_clk); while (full);
    endtask

    task automatic write_regs(logic [CW-1:0] stp, logic [CW-1:0] cnt);
        i_cfg_we    <= 1;
        i_cfg_index <= sfca_pkg::REG_GRID_STEP;
        i_cfg_data  <= stp;
        @(posedge i_clk);
        sb.set_reg(sfca_pkg::REG_GRID_STEP, stp);
        i_cfg_index <= sfca_pkg::REG_ATOM_COUNT;
        i_cfg_data  <= cnt;
        @(posedge i_clk);
        sb.set_reg(sfca_pkg::REG_ATOM_COUNT, cnt);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] rand_disp();
        case ($urandom_range(0, 3))
            0:       return DW'($urandom_range(0, 16383) - 8192);
            1:       return DW'($urandom_range(0, 255) - 128);
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic random_word();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 40)
            send_word(sfca_pkg::OP_ACC, rand_disp(), rand_disp(), rand_disp(),
                      IW'($urandom));
        else if (r < 88)
            send_word(sfca_pkg::OP_READ, DW'($urandom), DW'($urandom), DW'($urandom),
                      ($urandom_range(0, 9) == 0) ? IW'($urandom_range(CELLS, 511))
                                                  : IW'($urandom_range(0, CELLS - 1)));
        else if (r < 94)
            send_word(sfca_pkg::OP_CLEAR, DW'($urandom), DW'($urandom), DW'($urandom),
                      IW'($urandom));
        else
            send_word(OP_NONE, DW'($urandom), DW'($urandom), DW'($urandom),
                      IW'($urandom));
    endtask

    initial begin
        forever begin
            int gap;
            if (hold_req) begin
                hold_req = 0;
                pop <= 0;
                repeat (3000) @(posedge i_clk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty || !i_rst_n);
        end
    end

    logic [CW-1:0] steps  [6] = '{16'd4096, 16'd1, 16'd65535, 16'd0, 16'd12345, 16'd4096};
    logic [CW-1:0] counts [6] = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd7, 16'd1};

    initial begin
        sb = new();
        sb.reset_state();
        cycles       = 0;
        burst        = 0;
        hold_req     = 0;
        i_rst_n      = 0;
        push         = 0;
        pop          = 0;
        i_opcode     = sfca_pkg::OP_CLEAR;
        i_disp_x     = '0;
        i_disp_y     = '0;
        i_disp_z     = '0;
        i_read_index = '0;
        i_cfg_we     = 0;
        i_cfg_index  = sfca_pkg::REG_GRID_STEP;
        i_cfg_data   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            write_regs(steps[ph], counts[ph]);
            if (ph == 0) begin
                send_word(sfca_pkg::OP_READ, '0, '0, '0, '0);
                send_word(OP_NONE, 24'h7fffff, 24'h800000, 24'hffffff, 9'd5);
                send_word(sfca_pkg::OP_ACC, '0, '0, '0, '0);
                send_word(sfca_pkg::OP_ACC, 24'h7fffff, 24'h7fffff, 24'h7fffff, 9'h1ff);
                send_word(sfca_pkg::OP_ACC, 24'h800000, 24'h800000, 24'h800000, '0);
                send_word(sfca_pkg::OP_ACC, 24'hffffff, 24'h000001, 24'h001000, '0);
                send_word(sfca_pkg::OP_ACC, 24'h001921, 24'h000c90, 24'hffe6df, '0);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd0);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd171);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd147);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd342);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd343);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd511);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd100);
                send_word(sfca_pkg::OP_CLEAR, 24'hffffff, 24'hffffff, 24'hffffff, 9'h1ff);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd200);
                send_word(OP_NONE, '0, '0, '0, '0);
                send_word(sfca_pkg::OP_READ, '0, '0, '0, 9'd300);
            end
            if (ph == 2) begin
                hold_req = 1;
                repeat (20) send_word(sfca_pkg::OP_READ, '0, '0, '0,
                                      IW'($urandom_range(0, 511)));
            end
            for (int n = 0; n < 105; n++) begin
                if (n % 30 == 0) burst = ($urandom_range(0, 2) == 0);
                random_word();
            end
            burst = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> sim.f
design/sfca_pkg.sv
design/sfca_front.sv
design/sfca_modred.sv
design/sfca_div.sv
design/sfca_cordic.sv
design/sfca_back.sv
design/structure_factor_cosine_accumulator.sv
tb/sv/structure_factor_cosine_accumulator_tb.sv
